[rtl/tdf_pkg.sv]
// ---------------------------------------------------------------------------
// Trial division factorizer package
// Shared widths for the factorizer, its divider and its channel interfaces.
// ---------------------------------------------------------------------------
package tdf_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int FACTOR_WIDTH    = 64;

endpackage

[rtl/tdf_if.sv]
// ---------------------------------------------------------------------------
// Trial division factorizer channels
// Valid/ready interfaces for the input number and the factor items.
// ---------------------------------------------------------------------------
interface tdf_in_if #(
    parameter int VALUE_WIDTH = tdf_pkg::DEF_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if;
    logic                             valid;
    logic                             ready;
    logic [tdf_pkg::FACTOR_WIDTH-1:0] factor;
    logic                             last;
    logic                             no_factor;

    modport source (output valid, output factor, output last, output no_factor, input ready);
    modport sink   (input valid, input factor, input last, input no_factor, output ready);
endinterface

[rtl/tdf_divider.sv]
// ---------------------------------------------------------------------------
// Trial division factorizer divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tdf_divider #(
    parameter int VALUE_WIDTH = tdf_pkg::DEF_VALUE_WIDTH,
    parameter int DIV_WIDTH   = (tdf_pkg::DEF_VALUE_WIDTH + 1) / 2 + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]   i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [DIV_WIDTH-1:0]   o_remainder
);
    import tdf_pkg::*;

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [DIV_WIDTH-1:0]   r_dvs;
    logic [DIV_WIDTH:0]     w_shift;
    logic [DIV_WIDTH:0]     w_diff;
    logic                   w_ge;

    assign w_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_WIDTH-1:0] : w_shift[DIV_WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/trial_division_factorizer.sv]
// ---------------------------------------------------------------------------
// Trial division factorizer
// Splits an unsigned number into its prime factors in ascending order.
// ---------------------------------------------------------------------------
// Each accepted number yields its prime factors in ascending order with
// repeats, one item per factor, the final one flagged by last; an input of
// zero or one yields a single item with factor zero and no_factor set. The
// block takes one number at a time and raises ready only when it is idle.
// Every trial is a compare in the check state, a division in the shared
// restoring divider (one quotient bit per cycle) and a step to take its
// result. The divisors run 2 and then every odd number while their square
// stays at or below the cofactor, and a divisor that divides is tried again
// on the quotient. Each item is handed to the output register, and the
// search waits while that register is held full.
module trial_division_factorizer #(
    parameter int VALUE_WIDTH = tdf_pkg::DEF_VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdf_in_if.sink    i_in,
    tdf_out_if.source o_out
);
    import tdf_pkg::*;

    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = VALUE_WIDTH + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0]              r_state,    n_state;
    logic [VALUE_WIDTH-1:0]  r_cof,      n_cof;
    logic [DW-1:0]           r_dvs,      n_dvs;
    logic [SW-1:0]           r_sq,       n_sq;
    logic [FACTOR_WIDTH-1:0] r_pend_fac, n_pend_fac;
    logic                    r_pend_last, n_pend_last;
    logic                    r_pend_nf,  n_pend_nf;
    logic                    r_ovalid,   n_ovalid;
    logic [FACTOR_WIDTH-1:0] r_ofac,     n_ofac;
    logic                    r_olast,    n_olast;
    logic                    r_onf,      n_onf;

    logic                    w_sq_ok;
    logic                    w_start;
    logic                    w_div_done;
    logic [VALUE_WIDTH-1:0]  w_quo;
    logic [DW-1:0]           w_rem;
    logic                    w_out_free;

    assign w_sq_ok    = r_sq <= {1'b0, r_cof};
    assign w_start    = (r_state == S_CHECK) && w_sq_ok;
    assign w_out_free = !r_ovalid || o_out.ready;

    tdf_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dividend  (r_cof),
        .i_divisor   (r_dvs),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_cof       = r_cof;
        n_dvs       = r_dvs;
        n_sq        = r_sq;
        n_pend_fac  = r_pend_fac;
        n_pend_last = r_pend_last;
        n_pend_nf   = r_pend_nf;
        n_ovalid    = r_ovalid;
        n_ofac      = r_ofac;
        n_olast     = r_olast;
        n_onf       = r_onf;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.value < VALUE_WIDTH'(2)) begin
                        n_pend_fac  = '0;
                        n_pend_last = 1'b1;
                        n_pend_nf   = 1'b1;
                        n_state     = S_PUSH;
                    end else begin
                        n_cof   = i_in.value;
                        n_dvs   = DW'(2);
                        n_sq    = SW'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_sq_ok) begin
                    n_state = S_DIV;
                end else if (r_cof > VALUE_WIDTH'(1)) begin
                    n_pend_fac  = FACTOR_WIDTH'(r_cof);
                    n_pend_last = 1'b1;
                    n_pend_nf   = 1'b0;
                    n_state     = S_PUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_rem == '0) begin
                        n_cof       = w_quo;
                        n_pend_fac  = FACTOR_WIDTH'(r_dvs);
                        n_pend_last = (w_quo == VALUE_WIDTH'(1));
                        n_pend_nf   = 1'b0;
                        n_state     = S_PUSH;
                    end else begin
                        if (r_dvs == DW'(2)) begin
                            n_dvs = DW'(3);
                            n_sq  = SW'(9);
                        end else begin
                            n_dvs = r_dvs + DW'(2);
                            n_sq  = r_sq + SW'({r_dvs, 2'b00}) + SW'(4);
                        end
                        n_state = S_CHECK;
                    end
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ofac   = r_pend_fac;
                    n_olast  = r_pend_last;
                    n_onf    = r_pend_nf;
                    n_state  = r_pend_last ? S_IDLE : S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cof    <= '0;
            r_dvs    <= DW'(2);
            r_sq     <= SW'(4);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cof    <= n_cof;
            r_dvs    <= n_dvs;
            r_sq     <= n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_fac  <= n_pend_fac;
        r_pend_last <= n_pend_last;
        r_pend_nf   <= n_pend_nf;
        r_ofac      <= n_ofac;
        r_olast     <= n_olast;
        r_onf       <= n_onf;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.factor    = r_ofac;
    assign o_out.last      = r_olast;
    assign o_out.no_factor = r_onf;

    a_nf_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_factor) |-> (o_out.last && o_out.factor == '0))
        else $error("An item without factor must be the last one.");

    a_factor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.no_factor) |-> (o_out.factor >= FACTOR_WIDTH'(2)))
        else $error("A factor item carries a value below two.");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_sq_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_dvs >= DW'(2) && r_sq >= SW'(4)))
        else $error("Trial divisor or its square fell below the start value.");

endmodule
